// ===== rtl/mdrt_pkg.sv =====
// Shared types and constants of the microtile dirty rectangle tracker.
// Depends on nothing; mdrt_if, the top level, mdrt_clip and mdrt_checker import it.
`default_nettype none

package mdrt_pkg;

   localparam int TILE_SIZE_DEF     = 32;
   localparam int SCREEN_WIDTH_DEF  = 640;
   localparam int SCREEN_HEIGHT_DEF = 400;

   localparam int KIND_W     = 2;
   localparam int COORD_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int OUT_X_W    = 10;
   localparam int OUT_Y_W    = 9;

   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MAX_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MAX_Y = 2'd3;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADD,
      ST_CLEAR,
      ST_SCAN,
      ST_MERGE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [OUT_X_W-1:0] min_x;
      logic [OUT_Y_W-1:0] min_y;
      logic [OUT_X_W-1:0] max_x;
      logic [OUT_Y_W-1:0] max_y;
   } clip_type;

   localparam clip_type CLIP_RST = '{
      min_x: 10'd0,
      min_y: 9'd0,
      max_x: 10'd639,
      max_y: 9'd399
   };

   typedef struct packed {
      logic [OUT_X_W-1:0] rect_left;
      logic [OUT_Y_W-1:0] rect_top;
      logic [OUT_X_W-1:0] rect_right;
      logic [OUT_Y_W-1:0] rect_bottom;
      logic               done_res;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/mdrt_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on mdrt_pkg for field widths.
`default_nettype none

interface mdrt_req_if import mdrt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [COORD_W-1:0] left;
   logic signed [COORD_W-1:0] top;
   logic signed [COORD_W-1:0] right;
   logic signed [COORD_W-1:0] bottom;

   modport source (output valid, kind, left, top, right, bottom, input ready);
   modport sink (input valid, kind, left, top, right, bottom, output ready);
endinterface

interface mdrt_rsp_if import mdrt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OUT_X_W-1:0] rect_left;
   logic [OUT_Y_W-1:0] rect_top;
   logic [OUT_X_W-1:0] rect_right;
   logic [OUT_Y_W-1:0] rect_bottom;
   logic               done_res;

   modport source (output valid, rect_left, rect_top, rect_right, rect_bottom, done_res,
                   input ready);
   modport sink (input valid, rect_left, rect_top, rect_right, rect_bottom, done_res,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/microtile_dirty_rect_tracker.sv =====
// Microtile dirty rectangle tracker, top level.
// Depends on mdrt_pkg, mdrt_if, mdrt_ram, mdrt_grow and mdrt_clip.
//
// Usage:
//   req_ch carries one command per transfer: add a rectangle, clear all tiles, or
//   fetch the next dirty rectangle. Only a fetch produces a transfer on rsp_ch,
//   either a clipped rectangle with exclusive right/bottom edges or done.
//   The csr_ port writes the four clip window registers, one per cycle.
//   Tile boxes live in one RAM of TILE_COUNT entries (260 at default size),
//   read-modify-written one tile per cycle; the RAM port is the rate limit.
//   Add:   every tile is swept; an inverted rectangle is dropped without a sweep.
//   Clear: every tile is zeroed.
//   Fetch: tiles are scanned from where the last fetch stopped, then matching
//          tiles to the right in the same row are merged before the response.
//   One command is in flight at a time; req_ch.ready is high only when idle.
//   After reset a clearing pass zeroes the RAM; req_ch.ready stays low
//   meanwhile, csr_ writes are taken as usual.
//   A response waits in an output register while rsp_ch.ready is low; the next
//   command is still taken, and a later fetch holds its result until the
//   register frees.
`default_nettype none

module microtile_dirty_rect_tracker import mdrt_pkg::*; #(
   parameter int TILE_SIZE     = TILE_SIZE_DEF,
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mdrt_req_if.sink              req_ch,
   mdrt_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TILES_W    = (SCREEN_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
   localparam int TILES_H    = (SCREEN_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
   localparam int TILE_COUNT = TILES_W * TILES_H;
   localparam int LW         = $clog2(TILE_SIZE);
   localparam int BOX_W      = 4 * LW;
   localparam int XW         = $clog2(TILES_W * TILE_SIZE);
   localparam int YW         = $clog2(TILES_H * TILE_SIZE);
   localparam int AW         = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
   localparam int IDX_W      = $clog2(TILE_COUNT + 1);
   localparam int TX_W       = (TILES_W > 1) ? $clog2(TILES_W) : 1;
   localparam int TY_W       = $clog2(TILES_H + 1);
   localparam int CL_W       = COORD_W + 1;

   localparam logic [TX_W-1:0]  LAST_TX  = TX_W'(TILES_W - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE_COUNT - 1);
   localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(TILE_COUNT);
   localparam logic [LW-1:0]    LOC_MAX  = LW'(TILE_SIZE - 1);
   localparam logic [CL_W-1:0]  LIMIT_X  = CL_W'(SCREEN_WIDTH - 1);
   localparam logic [CL_W-1:0]  LIMIT_Y  = CL_W'(SCREEN_HEIGHT - 1);

   function automatic logic [CL_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] v,
                                                   input logic [CL_W-1:0] lim);
      logic [CL_W-1:0] mag;
      mag = CL_W'(v[COORD_W-2:0]);
      if (v[COORD_W-1]) begin
         return '0;
      end else if (mag > lim) begin
         return lim;
      end else begin
         return mag;
      end
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [TX_W-1:0]  rd_tx_ff, rd_tx_in;
   logic [TY_W-1:0]  rd_ty_ff, rd_ty_in;
   logic             st_vld_ff, st_vld_in;
   logic [IDX_W-1:0] st_idx_ff, st_idx_in;
   logic [TX_W-1:0]  st_tx_ff, st_tx_in;
   logic [TY_W-1:0]  st_ty_ff, st_ty_in;
   logic [IDX_W-1:0] cur_idx_ff, cur_idx_in;
   logic [TX_W-1:0]  cur_tx_ff, cur_tx_in;
   logic [TY_W-1:0]  cur_ty_ff, cur_ty_in;
   logic [XW-1:0]    rl_ff, rl_in, rr_ff, rr_in;
   logic [YW-1:0]    rt_ff, rt_in, rb_ff, rb_in;
   logic [BOX_W-1:0] box0_ff, box0_in;
   logic [TX_W-1:0]  fst_tx_ff, fst_tx_in;
   logic [TY_W-1:0]  fst_ty_ff, fst_ty_in;
   logic [TX_W-1:0]  lst_tx_ff, lst_tx_in;
   logic [IDX_W-1:0] lst_idx_ff, lst_idx_in;
   logic [LW-1:0]    lst_x1_ff, lst_x1_in;
   logic             done_ff, done_in;
   clip_type         clip_ff, clip_in;
   logic             rsp_vld_ff, rsp_vld_in;
   rsp_type          rsp_ff, rsp_in;

   logic             req_fire, rsp_free, rd_ok;
   logic             ram_rd_en, ram_wr_en, sweep_wr;
   logic [AW-1:0]    ram_wr_addr;
   logic [BOX_W-1:0] ram_wr_data, ram_rd_data;
   logic [XW-1:0]    cl_l, cl_r;
   logic [YW-1:0]    cl_t, cl_b;
   logic             add_ok;
   logic [LW-1:0]    d_x0, d_y0, d_x1, d_y1;
   logic [LW-1:0]    b_x0, b_y0, b_x1, b_y1;
   logic             scan_hit, scan_end, merge_go, absorb, merge_more;
   logic             grow_cov;
   logic [BOX_W-1:0] grow_box;
   logic [XW-1:0]    px0, px1;
   logic [YW-1:0]    py0, py1;
   rsp_type          clip_rsp;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_vld_ff || rsp_ch.ready;
   assign rd_ok    = (rd_idx_ff < END_IDX);

   assign cl_l = XW'(clamp_coord(req_ch.left, LIMIT_X));
   assign cl_r = XW'(clamp_coord(req_ch.right, LIMIT_X));
   assign cl_t = YW'(clamp_coord(req_ch.top, LIMIT_Y));
   assign cl_b = YW'(clamp_coord(req_ch.bottom, LIMIT_Y));
   assign add_ok = (cl_l <= cl_r) && (cl_t <= cl_b);

   assign {d_x0, d_y0, d_x1, d_y1} = ram_rd_data;
   assign {b_x0, b_y0, b_x1, b_y1} = box0_ff;

   assign scan_hit   = st_vld_ff && (ram_rd_data != '0);
   assign scan_end   = !scan_hit && (rd_idx_ff == END_IDX);
   assign merge_go   = (d_x1 == LOC_MAX) && (st_tx_ff != LAST_TX);
   assign absorb     = st_vld_ff && (d_y0 == b_y0) && (d_y1 == b_y1) && (d_x0 == '0);
   assign merge_more = absorb && (st_tx_ff != LAST_TX);

   mdrt_ram #(
      .WIDTH (BOX_W),
      .DEPTH (TILE_COUNT)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   mdrt_grow #(
      .TILE_SIZE (TILE_SIZE),
      .XW        (XW),
      .YW        (YW),
      .LW        (LW)
   ) u_grow (
      .base_x  (XW'(st_tx_ff * TILE_SIZE)),
      .base_y  (YW'(st_ty_ff * TILE_SIZE)),
      .rect_l  (rl_ff),
      .rect_t  (rt_ff),
      .rect_r  (rr_ff),
      .rect_b  (rb_ff),
      .old_box (ram_rd_data),
      .covered (grow_cov),
      .new_box (grow_box)
   );

   assign px0 = XW'(fst_tx_ff * TILE_SIZE) + XW'(b_x0);
   assign px1 = XW'(lst_tx_ff * TILE_SIZE) + XW'(lst_x1_ff);
   assign py0 = YW'(fst_ty_ff * TILE_SIZE) + YW'(b_y0);
   assign py1 = YW'(fst_ty_ff * TILE_SIZE) + YW'(b_y1);

   mdrt_clip #(
      .XW (XW),
      .YW (YW)
   ) u_clip (
      .px0  (px0),
      .py0  (py0),
      .px1  (px1),
      .py1  (py1),
      .clip (clip_ff),
      .done (done_ff),
      .rsp  (clip_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.kind)
                  KIND_ADD: begin
                     if (add_ok) begin
                        state_in = ST_ADD;
                     end
                  end
                  KIND_CLEAR: state_in = ST_CLEAR;
                  KIND_NEXT:  state_in = ST_SCAN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (st_vld_ff && (st_idx_ff == LAST_IDX)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = merge_go ? ST_MERGE : ST_EMIT;
            end else if (scan_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_MERGE: begin
            if (!merge_more) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      sweep_wr     = 1'b0;
      ram_wr_addr  = st_idx_ff[AW-1:0];
      ram_wr_data  = grow_box;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            sweep_wr    = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = rd_idx_ff[AW-1:0];
            ram_wr_data = '0;
         end
         ST_IDLE: req_ch.ready = 1'b1;
         ST_ADD: begin
            ram_rd_en = rd_ok;
            ram_wr_en = st_vld_ff && grow_cov;
         end
         ST_SCAN, ST_MERGE: ram_rd_en = rd_ok;
         ST_EMIT: ;
         default: ;
      endcase
   end

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      rd_tx_in   = rd_tx_ff;
      rd_ty_in   = rd_ty_ff;
      st_vld_in  = ram_rd_en;
      st_idx_in  = rd_idx_ff;
      st_tx_in   = rd_tx_ff;
      st_ty_in   = rd_ty_ff;
      cur_idx_in = cur_idx_ff;
      cur_tx_in  = cur_tx_ff;
      cur_ty_in  = cur_ty_ff;
      rl_in      = rl_ff;
      rr_in      = rr_ff;
      rt_in      = rt_ff;
      rb_in      = rb_ff;
      box0_in    = box0_ff;
      fst_tx_in  = fst_tx_ff;
      fst_ty_in  = fst_ty_ff;
      lst_tx_in  = lst_tx_ff;
      lst_idx_in = lst_idx_ff;
      lst_x1_in  = lst_x1_ff;
      done_in    = done_ff;
      clip_in    = clip_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      rsp_in     = rsp_ff;

      // advance the raster address
      if (ram_rd_en || sweep_wr) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
         if (rd_tx_ff == LAST_TX) begin
            rd_tx_in = '0;
            rd_ty_in = rd_ty_ff + TY_W'(1);
         end else begin
            rd_tx_in = rd_tx_ff + TX_W'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            rl_in = cl_l;
            rr_in = cl_r;
            rt_in = cl_t;
            rb_in = cl_b;
            if (req_ch.kind == KIND_NEXT) begin
               rd_idx_in = cur_idx_ff;
               rd_tx_in  = cur_tx_ff;
               rd_ty_in  = cur_ty_ff;
            end else begin
               rd_idx_in = '0;
               rd_tx_in  = '0;
               rd_ty_in  = '0;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               box0_in    = ram_rd_data;
               fst_tx_in  = st_tx_ff;
               fst_ty_in  = st_ty_ff;
               lst_tx_in  = st_tx_ff;
               lst_idx_in = st_idx_ff;
               lst_x1_in  = d_x1;
               done_in    = 1'b0;
            end else if (scan_end) begin
               done_in = 1'b1;
            end
         end
         ST_MERGE: begin
            if (absorb) begin
               lst_tx_in  = st_tx_ff;
               lst_idx_in = st_idx_ff;
               lst_x1_in  = d_x1;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = clip_rsp;
               if (done_ff) begin
                  cur_idx_in = '0;
                  cur_tx_in  = '0;
                  cur_ty_in  = '0;
               end else begin
                  cur_idx_in = lst_idx_ff + IDX_W'(1);
                  if (lst_tx_ff == LAST_TX) begin
                     cur_tx_in = '0;
                     cur_ty_in = fst_ty_ff + TY_W'(1);
                  end else begin
                     cur_tx_in = lst_tx_ff + TX_W'(1);
                     cur_ty_in = fst_ty_ff;
                  end
               end
            end
         end
         default: ;
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CLIP_MIN_X: clip_in.min_x = csr_wdata;
            CSR_CLIP_MIN_Y: clip_in.min_y = csr_wdata[OUT_Y_W-1:0];
            CSR_CLIP_MAX_X: clip_in.max_x = csr_wdata;
            CSR_CLIP_MAX_Y: clip_in.max_y = csr_wdata[OUT_Y_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         rd_idx_ff  <= '0;
         rd_tx_ff   <= '0;
         rd_ty_ff   <= '0;
         st_vld_ff  <= 1'b0;
         cur_idx_ff <= '0;
         cur_tx_ff  <= '0;
         cur_ty_ff  <= '0;
         clip_ff    <= CLIP_RST;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_idx_ff  <= rd_idx_in;
         rd_tx_ff   <= rd_tx_in;
         rd_ty_ff   <= rd_ty_in;
         st_vld_ff  <= st_vld_in;
         cur_idx_ff <= cur_idx_in;
         cur_tx_ff  <= cur_tx_in;
         cur_ty_ff  <= cur_ty_in;
         clip_ff    <= clip_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      st_idx_ff  <= st_idx_in;
      st_tx_ff   <= st_tx_in;
      st_ty_ff   <= st_ty_in;
      rl_ff      <= rl_in;
      rr_ff      <= rr_in;
      rt_ff      <= rt_in;
      rb_ff      <= rb_in;
      box0_ff    <= box0_in;
      fst_tx_ff  <= fst_tx_in;
      fst_ty_ff  <= fst_ty_in;
      lst_tx_ff  <= lst_tx_in;
      lst_idx_ff <= lst_idx_in;
      lst_x1_ff  <= lst_x1_in;
      done_ff    <= done_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.rect_left   = rsp_ff.rect_left;
   assign rsp_ch.rect_top    = rsp_ff.rect_top;
   assign rsp_ch.rect_right  = rsp_ff.rect_right;
   assign rsp_ch.rect_bottom = rsp_ff.rect_bottom;
   assign rsp_ch.done_res    = rsp_ff.done_res;

endmodule

`default_nettype wire

// ===== rtl/mdrt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module mdrt_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 260,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mdrt_grow.sv =====
// Tile update for an add: coverage test and bounding box growth of one tile.
// Pure logic; no package dependency.
`default_nettype none

module mdrt_grow #(
   parameter int TILE_SIZE = 32,
   parameter int XW = 10,
   parameter int YW = 9,
   parameter int LW = 5
) (
   input  logic [XW-1:0]   base_x,
   input  logic [YW-1:0]   base_y,
   input  logic [XW-1:0]   rect_l,
   input  logic [YW-1:0]   rect_t,
   input  logic [XW-1:0]   rect_r,
   input  logic [YW-1:0]   rect_b,
   input  logic [4*LW-1:0] old_box,
   output logic            covered,
   output logic [4*LW-1:0] new_box
);

   localparam logic [XW-1:0] SPAN_X  = XW'(TILE_SIZE - 1);
   localparam logic [YW-1:0] SPAN_Y  = YW'(TILE_SIZE - 1);
   localparam logic [LW-1:0] LOC_MAX = LW'(TILE_SIZE - 1);

   logic [XW-1:0] hi_x, dx0, dx1;
   logic [YW-1:0] hi_y, dy0, dy1;
   logic [LW-1:0] sx0, sy0, sx1, sy1;
   logic [LW-1:0] ox0, oy0, ox1, oy1;
   logic [LW-1:0] nx0, ny0, nx1, ny1;
   logic          occupied;

   always_comb begin
      hi_x = base_x + SPAN_X;
      hi_y = base_y + SPAN_Y;
      dx0  = rect_l - base_x;
      dx1  = rect_r - base_x;
      dy0  = rect_t - base_y;
      dy1  = rect_b - base_y;

      covered = (rect_r >= base_x) && (rect_l <= hi_x) &&
                (rect_b >= base_y) && (rect_t <= hi_y);

      sx0 = (rect_l > base_x) ? dx0[LW-1:0] : '0;
      sx1 = (rect_r < hi_x)   ? dx1[LW-1:0] : LOC_MAX;
      sy0 = (rect_t > base_y) ? dy0[LW-1:0] : '0;
      sy1 = (rect_b < hi_y)   ? dy1[LW-1:0] : LOC_MAX;

      {ox0, oy0, ox1, oy1} = old_box;
      occupied = (old_box != '0);

      nx0 = (occupied && (ox0 < sx0)) ? ox0 : sx0;
      ny0 = (occupied && (oy0 < sy0)) ? oy0 : sy0;
      nx1 = (occupied && (ox1 > sx1)) ? ox1 : sx1;
      ny1 = (occupied && (oy1 > sy1)) ? oy1 : sy1;

      new_box = {nx0, ny0, nx1, ny1};
   end

endmodule

`default_nettype wire

// ===== rtl/mdrt_clip.sv =====
// Result formatting: clip to the window registers, make edges exclusive, saturate.
// Depends on mdrt_pkg for clip_type and rsp_type.
`default_nettype none

module mdrt_clip import mdrt_pkg::*; #(
   parameter int XW = 10,
   parameter int YW = 9
) (
   input  logic [XW-1:0] px0,
   input  logic [YW-1:0] py0,
   input  logic [XW-1:0] px1,
   input  logic [YW-1:0] py1,
   input  clip_type      clip,
   input  logic          done,
   output rsp_type       rsp
);

   localparam int CXW = ((XW > OUT_X_W) ? XW : OUT_X_W) + 1;
   localparam int CYW = ((YW > OUT_Y_W) ? YW : OUT_Y_W) + 1;
   localparam logic [CXW-1:0] X_SAT = CXW'((1 << OUT_X_W) - 1);
   localparam logic [CYW-1:0] Y_SAT = CYW'((1 << OUT_Y_W) - 1);

   function automatic logic [CXW-1:0] clip_x(input logic [CXW-1:0] v,
                                             input logic [CXW-1:0] lo,
                                             input logic [CXW-1:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [CYW-1:0] clip_y(input logic [CYW-1:0] v,
                                             input logic [CYW-1:0] lo,
                                             input logic [CYW-1:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   logic [CXW-1:0] cx0, cx1, cx1p;
   logic [CYW-1:0] cy0, cy1, cy1p;

   always_comb begin
      cx0  = clip_x(CXW'(px0), CXW'(clip.min_x), CXW'(clip.max_x));
      cx1  = clip_x(CXW'(px1), CXW'(clip.min_x), CXW'(clip.max_x));
      cy0  = clip_y(CYW'(py0), CYW'(clip.min_y), CYW'(clip.max_y));
      cy1  = clip_y(CYW'(py1), CYW'(clip.min_y), CYW'(clip.max_y));
      cx1p = cx1 + CXW'(1);
      cy1p = cy1 + CYW'(1);

      if (done) begin
         rsp = '0;
         rsp.done_res = 1'b1;
      end else begin
         rsp.rect_left   = (cx0 > X_SAT)  ? X_SAT[OUT_X_W-1:0] : cx0[OUT_X_W-1:0];
         rsp.rect_top    = (cy0 > Y_SAT)  ? Y_SAT[OUT_Y_W-1:0] : cy0[OUT_Y_W-1:0];
         rsp.rect_right  = (cx1p > X_SAT) ? X_SAT[OUT_X_W-1:0] : cx1p[OUT_X_W-1:0];
         rsp.rect_bottom = (cy1p > Y_SAT) ? Y_SAT[OUT_Y_W-1:0] : cy1p[OUT_Y_W-1:0];
         rsp.done_res    = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mdrt_checker.sv =====
// Port-level checker for the tracker and the bind that attaches it.
// Depends on mdrt_pkg and on the top level's port names.
`default_nettype none

module mdrt_checker import mdrt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [KIND_W-1:0]  req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [OUT_X_W-1:0] rect_left,
   input logic [OUT_Y_W-1:0] rect_top,
   input logic [OUT_X_W-1:0] rect_right,
   input logic [OUT_Y_W-1:0] rect_bottom,
   input logic               done_res
);

   logic [1:0] pend_ff, pend_in;
   logic       fetch_fire, rsp_fire;

   assign fetch_fire = req_valid && req_ready && (req_kind == KIND_NEXT);
   assign rsp_fire   = rsp_valid && rsp_ready;

   // count fetches still owed a response
   always_comb begin
      pend_in = pend_ff;
      if (fetch_fire && !rsp_fire && (pend_ff != 2'd3)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!fetch_fire && rsp_fire && (pend_ff != 2'd0)) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_blocks_req: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted right after reset");

   a_rsp_needs_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("response without an outstanding fetch");

   a_done_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && done_res) |->
         (rect_left == '0) && (rect_top == '0) && (rect_right == '0) && (rect_bottom == '0))
      else $error("done response carries coordinates");

   a_rect_edges: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !done_res) |-> (rect_right != '0) && (rect_bottom != '0))
      else $error("rectangle with zero exclusive edge");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         rsp_valid && $stable({rect_left, rect_top, rect_right, rect_bottom, done_res}))
      else $error("stalled response changed");

endmodule

bind microtile_dirty_rect_tracker mdrt_checker u_mdrt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_kind    (req_ch.kind),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rect_left   (rsp_ch.rect_left),
   .rect_top    (rsp_ch.rect_top),
   .rect_right  (rsp_ch.rect_right),
   .rect_bottom (rsp_ch.rect_bottom),
   .done_res    (rsp_ch.done_res)
);

`default_nettype wire
